// File: design/i2dec_pkg.sv
package i2dec_pkg;

    // Default width of the converted integer.
    localparam int VALUE_WIDTH_DEF = 32;

    // Width of one output character code.
    localparam int TEXT_W = 6;

    // ASCII codes, truncated to the output character width.
    localparam logic [TEXT_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [TEXT_W-1:0] CHAR_MINUS = 6'd45;

    // Number of decimal digits needed for the largest magnitude 2**(w-1).
    function automatic int dec_digits(input int w);
        longint unsigned v;
        int n;
        v = 64'd1 << (w - 1);
        n = 0;
        while (v != 0) begin
            v = v / 10;
            n = n + 1;
        end
        return n;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_STRIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic strip;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done;
        logic strip_done;
        logic negative;
        logic out_free;
        logic last_digit;
    } t_stat;

endpackage

// File: design/i2dec_ctrl.sv
module i2dec_ctrl
    import i2dec_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                if (i_stat.conv_done) begin
                    n_state = ST_STRIP;
                end else begin
                    o_cmd.conv_step = 1'b1;
                end
            end
            ST_STRIP: begin
                // Drop leading zero digits, keeping at least one digit.
                if (i_stat.strip_done) begin
                    n_state = i_stat.negative ? ST_SIGN : ST_DIGIT;
                end else begin
                    o_cmd.strip = 1'b1;
                end
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.last_digit) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/i2dec_dp.sv
module i2dec_dp
    import i2dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [TEXT_W-1:0]       o_text_char,
    output logic                    o_last_char
);

    localparam int ND    = dec_digits(VALUE_WIDTH);
    localparam int BCD_W = ND * 4;
    localparam int BC_W  = $clog2(VALUE_WIDTH + 1);
    localparam int DC_W  = $clog2(ND + 1);

    logic [VALUE_WIDTH-1:0] r_mag;
    logic [BCD_W-1:0]       r_bcd;
    logic                   r_neg;
    logic [BC_W-1:0]        r_bitcnt;
    logic [DC_W-1:0]        r_cnt;
    logic                   r_out_valid;
    logic [TEXT_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        logic [3:0] d;
        for (int i = 0; i < ND; i++) begin
            d = r_bcd[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitcnt <= '0;
            r_cnt    <= '0;
        end else if (i_cmd.load) begin
            r_bitcnt <= BC_W'(VALUE_WIDTH);
            r_cnt    <= DC_W'(ND);
        end else if (i_cmd.conv_step) begin
            r_bitcnt <= r_bitcnt - 1'b1;
        end else if (i_cmd.strip || i_cmd.emit_digit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_WIDTH-1];
            r_mag <= i_value[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            r_bcd <= '0;
        end else if (i_cmd.conv_step) begin
            {r_bcd, r_mag} <= {bcd_adj[BCD_W-2:0], r_mag, 1'b0};
        end else if (i_cmd.strip || i_cmd.emit_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    // Output register: refilled in the cycle its beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= CHAR_ZERO + TEXT_W'(top_digit);
            r_out_last <= (r_cnt == DC_W'(1));
        end
    end

    assign o_stat.conv_done  = (r_bitcnt == '0);
    assign o_stat.strip_done = (top_digit != 4'd0) || (r_cnt == DC_W'(1));
    assign o_stat.negative   = r_neg;
    assign o_stat.out_free   = !r_out_valid || i_ready;
    assign o_stat.last_digit = (r_cnt == DC_W'(1));

    assign o_valid     = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load, i_cmd.conv_step, i_cmd.strip,
                  i_cmd.emit_sign, i_cmd.emit_digit}))
        else $error("more than one datapath command at once");

    a_conv_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.conv_step |-> (r_bitcnt != '0))
        else $error("conversion step past the last input bit");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_digit || i_cmd.strip) |-> (r_cnt != '0))
        else $error("digit consumed with no digits left");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_sign || i_cmd.emit_digit) |-> (!r_out_valid || i_ready))
        else $error("output beat overwritten before it was taken");
`endif

endmodule

// File: design/signed_int_to_decimal_ascii.sv
// Converts one signed two's complement integer of VALUE_WIDTH bits into its
// decimal ASCII text, sent out one character per output beat, most
// significant first. A negative value starts with a minus sign, and the most
// negative value prints in full with its sign. Zero gives a single '0' and
// leading zeros are never sent. The final character of each number has
// o_last_char set. Only the low six bits of each ASCII code are carried,
// which is enough for '-' and '0' to '9'. After an input beat is taken,
// bit-serial double dabble runs one step per input bit until the sequencer
// sees the bit count run out. Leading zero digits are then dropped at one
// per cycle, and the sequencer then finds the first digit to keep. The
// digits dropped plus the digits sent always equal the number of digits the
// BCD register holds, which is ten at 32 bits. Characters are then sent
// back to back when the output is not stalled. The block takes a new input
// beat as soon as the last character of the previous number sits in the
// output register, so a number's conversion overlaps the delivery of the
// previous final character.
module signed_int_to_decimal_ascii
    import i2dec_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [TEXT_W-1:0]       o_text_char,
    output logic                    o_last_char
);

    // Command and status between the sequencer and the datapath.
    t_cmd  cmd;
    t_stat stat;

    // The sequencer steps through load, conversion, leading zero removal,
    // sign and digit emission.
    i2dec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the magnitude shift register, the BCD digits and
    // the output register.
    i2dec_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

endmodule
